// ===== hdl/mtme_pkg.sv =====
// ---------------------------------------------------------------------------
// mtme_pkg: shared types and constants of the message tag matching engine
// request codes, status codes and field widths
// ---------------------------------------------------------------------------
package mtme_pkg;
  localparam int POSTED_DEPTH_DEF = 64;
  localparam int UNEXP_DEPTH_DEF  = 64;
  localparam int HANDLE_BITS_DEF  = 16;

  localparam int SRC_W = 16;
  localparam int TAG_W = 31;
  localparam int CTX_W = 16;
  localparam int HDL_W = 16;

  typedef enum logic [2:0] {
    REQ_MSG     = 3'd0,
    REQ_POST    = 3'd1,
    REQ_CANCEL  = 3'd2,
    REQ_PRB_UNX = 3'd3,
    REQ_PRB_PST = 3'd4
  } req_t;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_QUEUED   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;
endpackage

// ===== hdl/mtme_req_if.sv =====
// ---------------------------------------------------------------------------
// mtme_req_if: request channel
// valid/ready channel carrying one request item
// ---------------------------------------------------------------------------
interface mtme_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] source;
  logic        any_source;
  logic [30:0] tag;
  logic        any_tag;
  logic [15:0] context_req;
  logic [15:0] handle;
  logic        remove;
  modport source_mp (output valid, req_type, source, any_source, tag, any_tag,
                     context_req, handle, remove, input ready);
  modport sink (input valid, req_type, source, any_source, tag, any_tag,
                context_req, handle, remove, output ready);
endinterface

// ===== hdl/mtme_rsp_if.sv =====
// ---------------------------------------------------------------------------
// mtme_rsp_if: result channel
// valid/ready channel carrying one result item
// ---------------------------------------------------------------------------
interface mtme_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] match_handle;
  logic [15:0] match_source;
  logic [30:0] match_tag;
  modport source_mp (output valid, status, match_handle, match_source, match_tag,
                     input ready);
  modport sink (input valid, status, match_handle, match_source, match_tag,
                output ready);
endinterface

// ===== hdl/message_tag_matching_engine.sv =====
// ---------------------------------------------------------------------------
// message_tag_matching_engine: posted receive / unexpected message matcher
// two arrival-ordered queues in synchronous memories
// ---------------------------------------------------------------------------
// One request at a time. A request scans its queue one entry per cycle
// through the registered memory read port, stopping early at the first hit.
// A decide step follows, in which an append is one write. A removal then
// compacts the queue, moving one entry at a time by a read at k+1 in the
// shift state and a write at k in the shift-write state. An output state
// then raises the result valid. A new request is taken only once the
// previous result has been accepted. Queues are empty after reset; no
// clearing pass is needed since only entries below the fill count are read.
module message_tag_matching_engine #(
  parameter int POSTED_DEPTH = mtme_pkg::POSTED_DEPTH_DEF,
  parameter int UNEXP_DEPTH  = mtme_pkg::UNEXP_DEPTH_DEF,
  parameter int HANDLE_BITS  = mtme_pkg::HANDLE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  mtme_req_if.sink      in_ch,
  mtme_rsp_if.source_mp out_ch
);
  localparam int PA = (POSTED_DEPTH > 1) ? $clog2(POSTED_DEPTH) : 1;
  localparam int UA = (UNEXP_DEPTH > 1) ? $clog2(UNEXP_DEPTH) : 1;
  localparam int AW = (PA > UA) ? PA : UA;
  localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  // posted entry: wild(2) ctx tag src handle
  localparam int PW = 2 + 16 + 31 + 16 + HB;
  localparam int UW = 16 + 31 + 16 + HB;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT = 6'b001000,
    S_SHWR = 6'b010000,
    S_OUT = 6'b100000
  } state_t;

  // memories
  logic [PW-1:0] pmem [POSTED_DEPTH];
  logic [UW-1:0] umem [UNEXP_DEPTH];
  logic [PW-1:0] prd_r;
  logic [UW-1:0] urd_r;

  state_t state_r, state_nxt;
  logic [AW:0] pcnt_r, ucnt_r;
  logic [AW:0] idx_r;      // scan / shift index
  logic        rvld_r;     // a read for idx_r-1 is returning
  logic        found_r;
  logic        onp_r;      // request works on posted queue
  logic [2:0]  rt_r;
  logic [15:0] src_r, ctx_r;
  logic [30:0] tag_r;
  logic        asw_r, atw_r, rem_r;
  logic [HB-1:0] hd_r;
  logic [1:0]  st_r;
  logic [15:0] mh_r, ms_r;
  logic [30:0] mt_r;
  logic        ovld_r;

  // read port address and enables
  logic [AW:0] raddr;
  logic        pwe, uwe;
  logic [AW:0] waddr;
  logic [PW-1:0] pwd;
  logic [UW-1:0] uwd;

  // fields of the returned entry
  logic [1:0] e_wild;
  logic [15:0] e_ctx, e_src;
  logic [30:0] e_tag;
  logic [HB-1:0] e_hd;
  logic hit;
  logic [AW:0] cnt;

  assign cnt = onp_r ? pcnt_r : ucnt_r;

  always_comb begin
    if (onp_r) begin
      e_wild = prd_r[PW-1 -: 2];
      e_ctx  = prd_r[PW-3 -: 16];
      e_tag  = prd_r[PW-19 -: 31];
      e_src  = prd_r[HB+15 -: 16];
      e_hd   = prd_r[HB-1:0];
    end else begin
      e_wild = 2'b00;
      e_ctx  = urd_r[UW-1 -: 16];
      e_tag  = urd_r[UW-17 -: 31];
      e_src  = urd_r[HB+15 -: 16];
      e_hd   = urd_r[HB-1:0];
    end
    if (rt_r == mtme_pkg::REQ_CANCEL)
      hit = (e_hd == hd_r);
    else
      hit = (e_ctx == ctx_r) && (e_wild[1] || atw_r || e_tag == tag_r) &&
            (e_wild[0] || asw_r || e_src == src_r);
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (pwe) pmem[waddr[PA-1:0]] <= pwd;
    if (uwe) umem[waddr[UA-1:0]] <= uwd;
    prd_r <= pmem[raddr[PA-1:0]];
    urd_r <= umem[raddr[UA-1:0]];
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.status = st_r;
  assign out_ch.match_handle = mh_r;
  assign out_ch.match_source = ms_r;
  assign out_ch.match_tag = mt_r;

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    raddr = idx_r;
    pwe = 1'b0; uwe = 1'b0;
    waddr = idx_r;
    pwd = prd_r;
    uwd = urd_r;
    case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_SCAN;
      S_SCAN: begin
        if (rvld_r && hit) begin
          // read the hit entry again so it is on hand while deciding
          raddr = idx_r - 1'b1;
          state_nxt = S_DECIDE;
        end else if (idx_r >= cnt) state_nxt = rvld_r ? S_SCAN : S_DECIDE;
      end
      S_DECIDE: begin
        // append a message or post on a miss when its queue has room
        if (!found_r && (rt_r == mtme_pkg::REQ_MSG || rt_r == mtme_pkg::REQ_POST) &&
            !((rt_r == mtme_pkg::REQ_MSG) ? (ucnt_r >= (AW+1)'(UNEXP_DEPTH))
                                          : (pcnt_r >= (AW+1)'(POSTED_DEPTH)))) begin
          waddr = (rt_r == mtme_pkg::REQ_MSG) ? ucnt_r : pcnt_r;
          pwe = (rt_r == mtme_pkg::REQ_POST);
          uwe = (rt_r == mtme_pkg::REQ_MSG);
          pwd = {atw_r, asw_r, ctx_r, atw_r ? 31'd0 : tag_r,
                 asw_r ? 16'd0 : src_r, hd_r};
          uwd = {ctx_r, tag_r, src_r, hd_r};
        end
        // a removed entry is compacted out, the count drops at the end of the shift
        if (found_r && (rt_r == mtme_pkg::REQ_MSG || rt_r == mtme_pkg::REQ_POST ||
                        rt_r == mtme_pkg::REQ_CANCEL || rem_r))
          state_nxt = S_SHIFT;
        else
          state_nxt = S_OUT;
      end
      S_SHIFT: begin
        raddr = idx_r + 1'b1;
        state_nxt = (idx_r + 1'b1 >= cnt) ? S_OUT : S_SHWR;
      end
      S_SHWR: begin
        pwe = onp_r; uwe = !onp_r;
        state_nxt = S_SHIFT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r <= '0; ucnt_r <= '0;
      ovld_r <= 1'b0;
      rvld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovld_r && out_ch.ready) ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            rt_r <= in_ch.req_type;
            src_r <= in_ch.source; tag_r <= in_ch.tag; ctx_r <= in_ch.context_req;
            hd_r <= in_ch.handle[HB-1:0];
            rem_r <= in_ch.remove;
            asw_r <= in_ch.any_source && (in_ch.req_type != mtme_pkg::REQ_MSG);
            atw_r <= in_ch.any_tag && (in_ch.req_type != mtme_pkg::REQ_MSG);
            onp_r <= (in_ch.req_type == mtme_pkg::REQ_MSG) ||
                     (in_ch.req_type == mtme_pkg::REQ_CANCEL) ||
                     (in_ch.req_type == mtme_pkg::REQ_PRB_PST);
            // unknown codes scan nothing
            found_r <= 1'b0;
            idx_r <= '0;
            rvld_r <= 1'b0;
            st_r <= mtme_pkg::ST_NOTFOUND;
            mh_r <= '0; ms_r <= '0; mt_r <= '0;
          end
        end
        S_SCAN: begin
          if (rvld_r && hit) begin
            found_r <= 1'b1;
            idx_r <= idx_r - 1'b1;
            rvld_r <= 1'b0;
          end else if (idx_r < cnt && rt_r <= mtme_pkg::REQ_PRB_PST) begin
            idx_r <= idx_r + 1'b1;
            rvld_r <= 1'b1;
          end else begin
            if (idx_r < cnt) idx_r <= cnt;
            rvld_r <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (found_r) begin
            st_r <= mtme_pkg::ST_MATCH;
            mh_r <= 16'(e_hd);
            case (rt_r)
              mtme_pkg::REQ_MSG: begin ms_r <= src_r; mt_r <= tag_r; end
              mtme_pkg::REQ_CANCEL: begin ms_r <= '0; mt_r <= '0; end
              default: begin ms_r <= e_src; mt_r <= e_tag; end
            endcase
          end else if (rt_r == mtme_pkg::REQ_MSG) begin
            if (ucnt_r >= (AW+1)'(UNEXP_DEPTH)) st_r <= mtme_pkg::ST_FULL;
            else begin st_r <= mtme_pkg::ST_QUEUED; ucnt_r <= ucnt_r + 1'b1; end
          end else if (rt_r == mtme_pkg::REQ_POST) begin
            if (pcnt_r >= (AW+1)'(POSTED_DEPTH)) st_r <= mtme_pkg::ST_FULL;
            else begin st_r <= mtme_pkg::ST_QUEUED; pcnt_r <= pcnt_r + 1'b1; end
          end
        end
        S_SHIFT: begin
          if (idx_r + 1'b1 >= cnt) begin
            if (onp_r) pcnt_r <= pcnt_r - 1'b1;
            else ucnt_r <= ucnt_r - 1'b1;
          end
        end
        S_SHWR: idx_r <= idx_r + 1'b1;
        S_OUT: ovld_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/mtme_checker.sv =====
// ---------------------------------------------------------------------------
// mtme_checker: port-level checks of the matching engine
// bound to the top level
// ---------------------------------------------------------------------------
module mtme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [15:0] out_match_handle,
  input logic [15:0] out_match_source
);
  // a pending result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  // no request taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  // accepted item is not answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
  // queued, full or not-found results carry no handle and no source
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mtme_pkg::ST_QUEUED || out_status == mtme_pkg::ST_FULL ||
                  out_status == mtme_pkg::ST_NOTFOUND)
    |-> out_match_handle == 16'd0 && out_match_source == 16'd0)
    else $error("nonzero fields without match");
endmodule

bind message_tag_matching_engine mtme_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_match_handle(out_ch.match_handle), .out_match_source(out_ch.match_source)
);

// ===== dv/mtme_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// mtme_tb_pkg: matching scoreboard for the tag matching engine testbench
// keeps a shadow copy of both queues and predicts the result of each request
// ---------------------------------------------------------------------------
package mtme_tb_pkg;
  localparam int PDEPTH = mtme_pkg::POSTED_DEPTH_DEF;
  localparam int UDEPTH = mtme_pkg::UNEXP_DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] source;
    logic        any_source;
    logic [30:0] tag;
    logic        any_tag;
    logic [15:0] context_req;
    logic [15:0] handle;
    logic        remove;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] match_handle;
    logic [15:0] match_source;
    logic [30:0] match_tag;
  } outcome_t;

  // one entry of either queue; wild flags are always clear for unexpected ones
  typedef struct packed {
    logic [15:0] ctx;
    logic [30:0] tag;
    logic [15:0] src;
    logic        src_wild;
    logic        tag_wild;
    logic [15:0] hdl;
  } entry_t;

  class match_scoreboard;
    entry_t   posted_q[$];
    entry_t   unexp_q[$];
    outcome_t pending_q[$];
    int       n_errors;
    int       n_checked;
    int       n_matched;
    int       n_full;

    function int find_posted(request_t r, bit qsw, bit qtw);
      for (int i = 0; i < posted_q.size(); i++) begin
        if (posted_q[i].ctx == r.context_req &&
            (posted_q[i].tag_wild || qtw || posted_q[i].tag == r.tag) &&
            (posted_q[i].src_wild || qsw || posted_q[i].src == r.source))
          return i;
      end
      return -1;
    endfunction

    function int find_unexp(request_t r, bit qsw, bit qtw);
      for (int i = 0; i < unexp_q.size(); i++) begin
        if (unexp_q[i].ctx == r.context_req &&
            (qtw || unexp_q[i].tag == r.tag) &&
            (qsw || unexp_q[i].src == r.source))
          return i;
      end
      return -1;
    endfunction

    // work out the outcome of one accepted request and update the shadow queues
    function void note_request(request_t r);
      outcome_t o;
      entry_t   e;
      int       f;
      o = '{mtme_pkg::ST_NOTFOUND, 16'd0, 16'd0, 31'd0};
      case (r.req_type)
        mtme_pkg::REQ_MSG: begin
          f = find_posted(r, 1'b0, 1'b0);
          if (f >= 0) begin
            o = '{mtme_pkg::ST_MATCH, posted_q[f].hdl, r.source, r.tag};
            posted_q.delete(f);
          end else if (unexp_q.size() >= UDEPTH) begin
            o.status = mtme_pkg::ST_FULL;
          end else begin
            e = '{r.context_req, r.tag, r.source, 1'b0, 1'b0, r.handle};
            unexp_q.push_back(e);
            o.status = mtme_pkg::ST_QUEUED;
          end
        end
        mtme_pkg::REQ_POST: begin
          f = find_unexp(r, r.any_source, r.any_tag);
          if (f >= 0) begin
            o = '{mtme_pkg::ST_MATCH, unexp_q[f].hdl, unexp_q[f].src, unexp_q[f].tag};
            unexp_q.delete(f);
          end else if (posted_q.size() >= PDEPTH) begin
            o.status = mtme_pkg::ST_FULL;
          end else begin
            // wild fields are stored as zero
            e = '{r.context_req, r.any_tag ? 31'd0 : r.tag,
                  r.any_source ? 16'd0 : r.source, r.any_source, r.any_tag, r.handle};
            posted_q.push_back(e);
            o.status = mtme_pkg::ST_QUEUED;
          end
        end
        mtme_pkg::REQ_CANCEL: begin
          for (int i = 0; i < posted_q.size(); i++) begin
            if (posted_q[i].hdl == r.handle) begin
              o.status = mtme_pkg::ST_MATCH;
              o.match_handle = r.handle;
              posted_q.delete(i);
              break;
            end
          end
        end
        mtme_pkg::REQ_PRB_UNX: begin
          f = find_unexp(r, r.any_source, r.any_tag);
          if (f >= 0) begin
            o = '{mtme_pkg::ST_MATCH, unexp_q[f].hdl, unexp_q[f].src, unexp_q[f].tag};
            if (r.remove) unexp_q.delete(f);
          end
        end
        mtme_pkg::REQ_PRB_PST: begin
          f = find_posted(r, r.any_source, r.any_tag);
          if (f >= 0) begin
            o = '{mtme_pkg::ST_MATCH, posted_q[f].hdl, posted_q[f].src, posted_q[f].tag};
            if (r.remove) posted_q.delete(f);
          end
        end
        default: ;
      endcase
      if (o.status == mtme_pkg::ST_MATCH) n_matched++;
      if (o.status == mtme_pkg::ST_FULL) n_full++;
      pending_q.push_back(o);
    endfunction

    // compare one result with the oldest outstanding outcome
    function void check_result(outcome_t got);
      outcome_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected result item: status %0d handle %0h", got.status,
               got.match_handle);
        n_errors++;
        return;
      end
      exp = pending_q.pop_front();
      n_checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.match_handle !== exp.match_handle) begin
        $error("match_handle: expected %0h, got %0h", exp.match_handle, got.match_handle);
        n_errors++;
      end
      if (got.match_source !== exp.match_source) begin
        $error("match_source: expected %0h, got %0h", exp.match_source, got.match_source);
        n_errors++;
      end
      if (got.match_tag !== exp.match_tag) begin
        $error("match_tag: expected %0h, got %0h", exp.match_tag, got.match_tag);
        n_errors++;
      end
    endfunction
  endclass
endpackage

// ===== dv/message_tag_matching_engine_tb.sv =====
// ---------------------------------------------------------------------------
// message_tag_matching_engine_tb: self-checking bench of the matching engine
// drives directed and random request streams under varying backpressure and
// checks every result against a shadow model of both queues
// ---------------------------------------------------------------------------
module message_tag_matching_engine_tb;
  localparam int N_RANDOM  = 1800;
  localparam int MAX_CYCLE = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_cnt = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   n_sent = 0;

  mtme_req_if in_ch ();
  mtme_rsp_if out_ch ();

  mtme_tb_pkg::match_scoreboard sb = new();

  message_tag_matching_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall, check on each accepted item
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.status, out_ch.match_handle, out_ch.match_source,
                        out_ch.match_tag});
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // present one item, hold it until accepted; within this task valid drops only in idle gaps
  task automatic send_request(mtme_tb_pkg::request_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.req_type;
    in_ch.source <= r.source;
    in_ch.any_source <= r.any_source;
    in_ch.tag <= r.tag;
    in_ch.any_tag <= r.any_tag;
    in_ch.context_req <= r.context_req;
    in_ch.handle <= r.handle;
    in_ch.remove <= r.remove;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    n_sent++;
  endtask

  function automatic mtme_tb_pkg::request_t make_req(logic [2:0] kind, logic [15:0] src,
                                                     bit asw, logic [30:0] tg, bit atw,
                                                     logic [15:0] ctx, logic [15:0] hdl,
                                                     bit rem);
    mtme_tb_pkg::request_t r;
    r = '{kind, src, asw, tg, atw, ctx, hdl, rem};
    return r;
  endfunction

  // random request; narrow pools for source, tag, context and handle give matches
  function automatic mtme_tb_pkg::request_t rand_req();
    mtme_tb_pkg::request_t r;
    int       k;
    k = $urandom_range(99);
    r.req_type = (k < 35) ? mtme_pkg::REQ_MSG : (k < 70) ? mtme_pkg::REQ_POST :
                 (k < 78) ? mtme_pkg::REQ_CANCEL : (k < 87) ? mtme_pkg::REQ_PRB_UNX :
                 (k < 96) ? mtme_pkg::REQ_PRB_PST : 3'($urandom_range(7, 5));
    r.source = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    r.tag = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(3));
    r.context_req = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1));
    r.handle = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    r.any_source = ($urandom_range(3) == 0);
    r.any_tag = ($urandom_range(3) == 0);
    r.remove = 1'($urandom_range(1));
    return r;
  endfunction

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    // input side at known values from time zero
    in_ch.valid = 1'b0;
    in_ch.req_type = mtme_pkg::REQ_MSG;
    in_ch.source = '0;
    in_ch.any_source = 1'b0;
    in_ch.tag = '0;
    in_ch.any_tag = 1'b0;
    in_ch.context_req = '0;
    in_ch.handle = '0;
    in_ch.remove = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queues, extremes, wildcards, every request type
    send_request(make_req(mtme_pkg::REQ_PRB_UNX, 16'hffff, 1'b1, 31'h7fffffff, 1'b1,
                          16'hffff, 16'h0, 1'b1));
    send_request(make_req(mtme_pkg::REQ_PRB_PST, 16'h0, 1'b1, 31'h0, 1'b1, 16'h0, 16'h0,
                          1'b1));
    send_request(make_req(mtme_pkg::REQ_CANCEL, 16'h0, 1'b0, 31'h0, 1'b0, 16'h0, 16'hffff,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_MSG, 16'hffff, 1'b1, 31'h7fffffff, 1'b1, 16'hffff,
                          16'hffff, 1'b0));
    send_request(make_req(mtme_pkg::REQ_POST, 16'hffff, 1'b0, 31'h7fffffff, 1'b0,
                          16'hffff, 16'h1, 1'b0));
    send_request(make_req(mtme_pkg::REQ_POST, 16'h5, 1'b1, 31'h9, 1'b1, 16'h7, 16'h2,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_PRB_PST, 16'h1, 1'b0, 31'h2, 1'b0, 16'h7, 16'h0,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_MSG, 16'h1234, 1'b0, 31'h55aa, 1'b0, 16'h7, 16'h3,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_MSG, 16'h0, 1'b0, 31'h0, 1'b0, 16'h0, 16'h0,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_PRB_UNX, 16'h9, 1'b1, 31'h0, 1'b0, 16'h0, 16'h0,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_POST, 16'h0, 1'b1, 31'h9, 1'b1, 16'h0, 16'h4,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_POST, 16'h0, 1'b0, 31'h9, 1'b1, 16'h8, 16'h5,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_CANCEL, 16'h0, 1'b0, 31'h0, 1'b0, 16'h0, 16'h5,
                          1'b0));
    send_request(make_req(mtme_pkg::REQ_CANCEL, 16'h0, 1'b0, 31'h0, 1'b0, 16'h0, 16'h5,
                          1'b0));
    // codes above the last request type
    send_request(make_req(3'd5, 16'hffff, 1'b1, 31'h7fffffff, 1'b1, 16'hffff, 16'hffff,
                          1'b1));
    send_request(make_req(3'd7, 16'h0, 1'b0, 31'h0, 1'b0, 16'h0, 16'h0, 1'b0));
    // fill the unexpected queue past its depth
    for (int i = 0; i < mtme_tb_pkg::UDEPTH + 2; i++)
      send_request(make_req(mtme_pkg::REQ_MSG, 16'(i), 1'b0, 31'(i), 1'b0, 16'h3, 16'(i),
                            1'b0));
    for (int i = 0; i < mtme_tb_pkg::UDEPTH; i++)
      send_request(make_req(mtme_pkg::REQ_PRB_UNX, 16'h0, 1'b1, 31'h0, 1'b1, 16'h3, 16'h0,
                            1'b1));
    // fill the posted queue past its depth
    for (int i = 0; i < mtme_tb_pkg::PDEPTH + 2; i++)
      send_request(make_req(mtme_pkg::REQ_POST, 16'(i), i[0], 31'(i), i[1], 16'h4, 16'(i),
                            1'b0));
    for (int i = 0; i < mtme_tb_pkg::PDEPTH; i++)
      send_request(make_req(mtme_pkg::REQ_PRB_PST, 16'h0, 1'b1, 31'h0, 1'b1, 16'h4, 16'h0,
                            1'b1));
    wait_drained();

    // random phases with different source idling and result stalling
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 48) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 48) : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        send_request(rand_req());
        if (i == 200) wait_drained();
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("run covered %0d requests, %0d results checked, %0d matches, %0d full",
             n_sent, sb.n_checked, sb.n_matched, sb.n_full);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mtme_pkg.sv
hdl/mtme_req_if.sv
hdl/mtme_rsp_if.sv
hdl/message_tag_matching_engine.sv
hdl/mtme_checker.sv
dv/mtme_tb_pkg.sv
dv/message_tag_matching_engine_tb.sv
